// File: rtl/cfr_pkg.sv
// Package: types, constants and codes shared by the chunked frame reassembler.
package cfr_pkg;

    localparam int CFR_SLOTS        = 4;
    localparam int CFR_MAX_CHUNKS   = 64;
    localparam int CFR_MAX_DATAGRAM = 1500;
    localparam int HEADER_BYTES     = 24;
    localparam int MAX_STRIDE       = 1476;
    localparam logic [15:0] JPEG_SOI = 16'hFFD8;
    localparam logic [15:0] STALE_MS_RESET      = 16'd200;
    localparam logic [10:0] CHUNK_PAYLOAD_RESET = 11'd1376;

    typedef enum logic [0:0] {
        CMD_PACKET = 1'b0,
        CMD_SWEEP  = 1'b1
    } cmd_t;

    typedef enum logic [3:0] {
        ST_STORED     = 4'd0,
        ST_DUPLICATE  = 4'd1,
        ST_BAD_HEADER = 4'd2,
        ST_OLD_FRAME  = 4'd3,
        ST_BAD_OFFSET = 4'd4,
        ST_NO_SLOT    = 4'd5,
        ST_PUBLISHED  = 4'd6,
        ST_NOT_JPEG   = 4'd7,
        ST_SWEEP_DONE = 4'd8
    } status_t;

    typedef enum logic [0:0] {
        REG_STALE_MS      = 1'b0,
        REG_CHUNK_PAYLOAD = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_LOOKUP,
        FSM_CHECK,
        FSM_UPDATE,
        FSM_OUTPUT
    } fsm_state_t;

    typedef struct packed {
        logic [0:0]  command;
        logic [31:0] now_ms;
        logic [10:0] datagram_len;
        logic [31:0] frame_num;
        logic [15:0] chunk_index;
        logic [15:0] chunk_count;
        logic [31:0] chunk_bytes;
        logic [31:0] frame_bytes;
        logic [15:0] payload_head;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [16:0] write_offset;
        logic [1:0]  buffer_slot;
        logic [31:0] frame_num_out;
        logic [16:0] frame_size;
        logic [2:0]  dropped_count;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic lookup;
        logic check;
        logic update;
    } dp_cmd_t;

endpackage

// File: rtl/cfr_ctrl.sv
// Controller: sequences one item through lookup, check, update and output.
module cfr_ctrl
    import cfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t cmd
);

    fsm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            FSM_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = FSM_LOOKUP;
                end
            end
            FSM_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = FSM_CHECK;
            end
            FSM_CHECK: begin
                cmd.check  = 1'b1;
                state_next = FSM_UPDATE;
            end
            FSM_UPDATE: begin
                cmd.update = 1'b1;
                state_next = FSM_OUTPUT;
            end
            FSM_OUTPUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

endmodule

// File: rtl/cfr_datapath.sv
// Datapath: slot table, header checks, offset multiply and result register.
module cfr_datapath
    import cfr_pkg::*;
#(
    parameter int SLOTS      = CFR_SLOTS,
    parameter int MAX_CHUNKS = CFR_MAX_CHUNKS,
    parameter int MAX_DGRAM  = CFR_MAX_DATAGRAM
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  dp_cmd_t   cmd,
    input  in_item_t  s_item,
    input  logic      cfg_valid,
    input  logic      cfg_index,
    input  logic [15:0] cfg_data,
    output out_item_t m_item
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam int MW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam logic [31:0] MAX_FRAME = 32'(MAX_CHUNKS * MAX_STRIDE);

    logic [15:0] stale_ms_reg;
    logic [10:0] chunk_payload_reg;

    logic [SLOTS-1:0]      slot_valid_reg;
    logic [31:0]           slot_frame_num_reg    [SLOTS];
    logic [16:0]           slot_total_size_reg   [SLOTS];
    logic [CW-1:0]         slot_total_chunks_reg [SLOTS];
    logic [CW-1:0]         slot_received_reg     [SLOTS];
    logic [MAX_CHUNKS-1:0] slot_chunk_mask_reg   [SLOTS];
    logic [31:0]           slot_first_seen_reg   [SLOTS];
    logic [15:0]           slot_head_bytes_reg   [SLOTS];
    logic [31:0]           last_done_id_reg;
    logic                  have_done_reg;

    in_item_t    item_reg;
    out_item_t   res_reg;
    logic        bad_hdr_reg;
    logic        hit_reg;
    logic        free_ok_reg;
    logic [SW-1:0] slot_reg;
    logic [32:0] off_reg;
    logic [SLOTS-1:0] stale_reg;

    logic        bad_hdr;
    logic        hit, free_ok;
    logic [SW-1:0] hit_idx, free_idx;
    logic [SLOTS-1:0] stale;
    logic [2:0]  drop_cnt;

    always_comb begin
        bad_hdr = (item_reg.datagram_len < 11'(HEADER_BYTES))
               || (item_reg.datagram_len > 11'(MAX_DGRAM))
               || (item_reg.chunk_count == 16'd0)
               || (item_reg.chunk_count > 16'(MAX_CHUNKS))
               || (item_reg.chunk_index >= item_reg.chunk_count)
               || (item_reg.chunk_bytes == 32'd0)
               || (item_reg.chunk_bytes > 32'(chunk_payload_reg))
               || ({1'b0, item_reg.chunk_bytes} + 33'(HEADER_BYTES)
                   > 33'(item_reg.datagram_len))
               || (item_reg.frame_bytes > MAX_FRAME);
        hit = 1'b0; free_ok = 1'b0; hit_idx = '0; free_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (slot_valid_reg[s] && slot_frame_num_reg[s] == item_reg.frame_num) begin
                hit = 1'b1; hit_idx = SW'(s);
            end
            if (!slot_valid_reg[s]) begin
                free_ok = 1'b1; free_idx = SW'(s);
            end
        end
        drop_cnt = '0;
        for (int s = 0; s < SLOTS; s++) begin
            stale[s] = slot_valid_reg[s]
                && ((item_reg.now_ms - slot_first_seen_reg[s]) > 32'(stale_ms_reg));
        end
        for (int s = 0; s < SLOTS; s++) begin
            drop_cnt = drop_cnt + 3'(stale_reg[s]);
        end
    end

    // Update-stage values for the chosen slot.
    logic [MW-1:0]   bit_idx;
    logic [CW-1:0]   tot_chunks;
    logic [16:0]     tot_size;
    logic [MAX_CHUNKS-1:0] mask_cur;
    logic [CW-1:0]   rcv_cur, rcv_new;
    logic [15:0]     head_cur, head_new;
    logic            range_bad, dup, done;
    logic [33:0]     end_pos;
    logic            old_frame;
    logic            slot_write;
    out_item_t       res_next;

    always_comb begin
        bit_idx    = item_reg.chunk_index[MW-1:0];
        tot_chunks = hit_reg ? slot_total_chunks_reg[slot_reg] : CW'(item_reg.chunk_count);
        tot_size   = hit_reg ? slot_total_size_reg[slot_reg] : item_reg.frame_bytes[16:0];
        mask_cur   = hit_reg ? slot_chunk_mask_reg[slot_reg] : '0;
        rcv_cur    = hit_reg ? slot_received_reg[slot_reg] : '0;
        head_cur   = hit_reg ? slot_head_bytes_reg[slot_reg] : '0;
        end_pos    = {1'b0, off_reg} + {2'b0, item_reg.chunk_bytes};
        range_bad  = (item_reg.chunk_index >= 16'(tot_chunks))
                  || (end_pos > 34'(tot_size))
                  || (!hit_reg && item_reg.frame_bytes[31:17] != '0
                      && end_pos > 34'(item_reg.frame_bytes));
        dup        = mask_cur[bit_idx];
        rcv_new    = rcv_cur + CW'(1);
        head_new   = head_cur;
        if (item_reg.chunk_index == 16'd0) begin
            head_new[15:8] = item_reg.payload_head[15:8];
            if (item_reg.chunk_bytes >= 32'd2) begin
                head_new[7:0] = item_reg.payload_head[7:0];
            end
        end else if (item_reg.chunk_index == 16'd1 && chunk_payload_reg == 11'd1) begin
            head_new[7:0] = item_reg.payload_head[15:8];
        end
        done = (rcv_new == tot_chunks);
        old_frame  = have_done_reg && (item_reg.frame_num <= last_done_id_reg);
        slot_write = (item_reg.command == CMD_PACKET) && !bad_hdr_reg && !old_frame
                  && (hit_reg || free_ok_reg) && !range_bad && !dup && !done;

        res_next = '0;
        if (item_reg.command == CMD_SWEEP) begin
            res_next.status        = ST_SWEEP_DONE;
            res_next.dropped_count = drop_cnt;
        end else begin
            res_next.frame_num_out = item_reg.frame_num;
            if (bad_hdr_reg) begin
                res_next.status = ST_BAD_HEADER;
            end else if (old_frame) begin
                res_next.status = ST_OLD_FRAME;
            end else if (!hit_reg && !free_ok_reg) begin
                res_next.status = ST_NO_SLOT;
            end else begin
                res_next.write_offset = off_reg[16:0];
                res_next.buffer_slot  = 2'(slot_reg);
                if (range_bad) begin
                    res_next.status = ST_BAD_OFFSET;
                end else if (dup) begin
                    res_next.status = ST_DUPLICATE;
                end else if (done) begin
                    res_next.frame_size = tot_size;
                    res_next.status = (tot_size >= 17'd4 && head_new == JPEG_SOI)
                                    ? ST_PUBLISHED : ST_NOT_JPEG;
                end else begin
                    res_next.status = ST_STORED;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stale_ms_reg      <= STALE_MS_RESET;
            chunk_payload_reg <= CHUNK_PAYLOAD_RESET;
            slot_valid_reg    <= '0;
            have_done_reg     <= 1'b0;
            last_done_id_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_STALE_MS) stale_ms_reg <= cfg_data;
                else chunk_payload_reg <= cfg_data[10:0];
            end
            if (cmd.update) begin
                if (item_reg.command == CMD_SWEEP) begin
                    slot_valid_reg <= slot_valid_reg & ~stale_reg;
                end else if (!bad_hdr_reg && !old_frame && (hit_reg || free_ok_reg)) begin
                    if (range_bad) begin
                        slot_valid_reg[slot_reg] <= 1'b0;
                    end else if (!dup) begin
                        if (done) begin
                            slot_valid_reg[slot_reg] <= 1'b0;
                            last_done_id_reg <= item_reg.frame_num;
                            have_done_reg    <= 1'b1;
                        end else begin
                            slot_valid_reg[slot_reg] <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) item_reg <= s_item;
        if (cmd.lookup) begin
            bad_hdr_reg <= bad_hdr;
            hit_reg     <= hit;
            free_ok_reg <= free_ok;
            slot_reg    <= hit ? hit_idx : free_idx;
            stale_reg   <= stale;
        end
        if (cmd.check) begin
            off_reg <= {1'b0, 32'(item_reg.chunk_index) * 32'(chunk_payload_reg)};
        end
        if (cmd.update) begin
            res_reg <= res_next;
            if (slot_write) begin
                if (!hit_reg) begin
                    slot_frame_num_reg[slot_reg]    <= item_reg.frame_num;
                    slot_total_size_reg[slot_reg]   <= item_reg.frame_bytes[16:0];
                    slot_total_chunks_reg[slot_reg] <= CW'(item_reg.chunk_count);
                    slot_first_seen_reg[slot_reg]   <= item_reg.now_ms;
                end
                slot_chunk_mask_reg[slot_reg] <= mask_cur | (MAX_CHUNKS'(1) << bit_idx);
                slot_received_reg[slot_reg]   <= rcv_new;
                slot_head_bytes_reg[slot_reg] <= head_new;
            end
        end
    end

    assign m_item = res_reg;

endmodule

// File: rtl/chunked_frame_reassembler_core.sv
// Top level: chunked frame reassembler, controller plus datapath.
// An item accepted on s_ goes through load, slot lookup, the chunk offset
// multiply and the slot update; its result is offered on m_ in the output state
// and held until taken. One item is in flight at a time; s_ready returns in the
// cycle after the result transfer. Config writes are always accepted and apply
// at once.
module chunked_frame_reassembler_core
    import cfr_pkg::*;
#(
    parameter int SLOTS      = CFR_SLOTS,
    parameter int MAX_CHUNKS = CFR_MAX_CHUNKS,
    parameter int MAX_DGRAM  = CFR_MAX_DATAGRAM
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    cfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    cfr_datapath #(
        .SLOTS      (SLOTS),
        .MAX_CHUNKS (MAX_CHUNKS),
        .MAX_DGRAM  (MAX_DGRAM)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_item    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_item    (m_data)
    );

endmodule

// File: verif/tb_top.sv
// Testbench for the chunked frame reassembler: random and directed header traffic.
`timescale 1ns / 1ps

class reassembly_board;
    logic [15:0] stale_ms;
    logic [10:0] stride;
    logic        valid_q [4];
    logic [31:0] fid_q [4];
    logic [16:0] size_q [4];
    logic [6:0]  chunks_q [4];
    logic [6:0]  rcvd_q [4];
    logic [63:0] mask_q [4];
    logic [31:0] seen_q [4];
    logic [15:0] head_q [4];
    logic [31:0] last_done;
    logic        have_done;
    cfr_pkg::out_item_t pending [$];
    int errors;

    function new();
        errors = 0;
        stale_ms = cfr_pkg::STALE_MS_RESET;
        stride = cfr_pkg::CHUNK_PAYLOAD_RESET;
        last_done = 0;
        have_done = 0;
        for (int s = 0; s < 4; s++) clear_slot(s);
    endfunction

    function void clear_slot(int s);
        valid_q[s] = 0; fid_q[s] = 0; size_q[s] = 0; chunks_q[s] = 0;
        rcvd_q[s] = 0; mask_q[s] = 0; seen_q[s] = 0; head_q[s] = 0;
    endfunction

    function void write_reg(cfr_pkg::reg_idx_t idx, logic [15:0] val);
        if (idx == cfr_pkg::REG_STALE_MS) stale_ms = val;
        else stride = val[10:0];
    endfunction

    function void note_item(cfr_pkg::in_item_t it);
        cfr_pkg::out_item_t r;
        int slot;
        logic [63:0] off;
        r = '0;
        slot = -1;
        if (it.command == cfr_pkg::CMD_SWEEP) begin
            r.status = cfr_pkg::ST_SWEEP_DONE;
            for (int s = 0; s < 4; s++)
                if (valid_q[s] && (it.now_ms - seen_q[s]) > {16'd0, stale_ms}) begin
                    clear_slot(s);
                    r.dropped_count++;
                end
            pending.push_back(r);
            return;
        end
        r.frame_num_out = it.frame_num;
        if (it.datagram_len < 24 || it.datagram_len > 1500 || it.chunk_count == 0 ||
            it.chunk_count > 64 || it.chunk_index >= it.chunk_count ||
            it.chunk_bytes == 0 || it.chunk_bytes > stride ||
            64'd24 + it.chunk_bytes > it.datagram_len || it.frame_bytes > 64 * 1476) begin
            r.status = cfr_pkg::ST_BAD_HEADER;
            pending.push_back(r);
            return;
        end
        if (have_done && it.frame_num <= last_done) begin
            r.status = cfr_pkg::ST_OLD_FRAME;
            pending.push_back(r);
            return;
        end
        for (int s = 0; s < 4; s++)
            if (slot < 0 && valid_q[s] && fid_q[s] == it.frame_num) slot = s;
        if (slot < 0) begin
            for (int s = 0; s < 4; s++)
                if (slot < 0 && !valid_q[s]) slot = s;
            if (slot < 0) begin
                r.status = cfr_pkg::ST_NO_SLOT;
                pending.push_back(r);
                return;
            end
            clear_slot(slot);
            valid_q[slot] = 1;
            fid_q[slot] = it.frame_num;
            size_q[slot] = it.frame_bytes[16:0];
            chunks_q[slot] = it.chunk_count[6:0];
            seen_q[slot] = it.now_ms;
        end
        off = 64'(it.chunk_index) * 64'(stride);
        r.write_offset = off[16:0];
        r.buffer_slot = slot[1:0];
        if (it.chunk_index >= chunks_q[slot] || off + it.chunk_bytes > size_q[slot]) begin
            clear_slot(slot);
            r.status = cfr_pkg::ST_BAD_OFFSET;
            pending.push_back(r);
            return;
        end
        if (mask_q[slot][it.chunk_index[5:0]]) begin
            r.status = cfr_pkg::ST_DUPLICATE;
            pending.push_back(r);
            return;
        end
        mask_q[slot][it.chunk_index[5:0]] = 1;
        rcvd_q[slot]++;
        if (it.chunk_index == 0) begin
            head_q[slot][15:8] = it.payload_head[15:8];
            if (it.chunk_bytes >= 2) head_q[slot][7:0] = it.payload_head[7:0];
        end else if (it.chunk_index == 1 && stride == 1) begin
            head_q[slot][7:0] = it.payload_head[15:8];
        end
        if (rcvd_q[slot] == chunks_q[slot]) begin
            r.frame_size = size_q[slot];
            r.status = (size_q[slot] >= 4 && head_q[slot] == cfr_pkg::JPEG_SOI) ?
                       cfr_pkg::ST_PUBLISHED : cfr_pkg::ST_NOT_JPEG;
            last_done = it.frame_num;
            have_done = 1;
            clear_slot(slot);
        end else begin
            r.status = cfr_pkg::ST_STORED;
        end
        pending.push_back(r);
    endfunction

    function void check_result(cfr_pkg::out_item_t got);
        cfr_pkg::out_item_t exp;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
        end
        exp = pending.pop_front();
        if (got !== exp) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", exp, got);
        end
    endfunction
endclass

module tb_top;
    import cfr_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    out_item_t   m_data;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic        cfg_index = 0;
    logic [15:0] cfg_data = 0;

    reassembly_board board = new();
    logic        calm = 0;
    logic [31:0] clock_ms = 1000;
    logic [31:0] next_fid = 1;

    chunked_frame_reassembler_core uut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    initial begin
        #50_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
    end

    initial begin
        int gap;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 8);
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1;
        end
    end

    task automatic send_item(in_item_t it);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        board.note_item(it);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, val);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    function automatic in_item_t chunk_item(logic [31:0] fid, int idx, int cnt, int fbytes,
                                            logic [15:0] head);
        in_item_t it;
        int cb;
        it = '0;
        it.command = CMD_PACKET;
        clock_ms += $urandom_range(0, 20);
        it.now_ms = clock_ms;
        it.frame_num = fid;
        it.chunk_index = 16'(idx);
        it.chunk_count = 16'(cnt);
        it.frame_bytes = 32'(fbytes);
        cb = fbytes - idx * int'(board.stride);
        if (cb > int'(board.stride)) cb = int'(board.stride);
        if (cb < 1) cb = 1;
        it.chunk_bytes = 32'(cb);
        it.datagram_len = 11'(24 + cb + int'($urandom_range(0, 1476 - cb)));
        it.payload_head = head;
        return it;
    endfunction

    function automatic in_item_t noise_item();
        in_item_t it;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        it.command = CMD_PACKET;
        case ($urandom_range(0, 3))
            0: ;
            1: begin
                it.datagram_len = 11'($urandom_range(0, 1600));
                it.chunk_count = 16'($urandom_range(0, 70));
                it.chunk_index = 16'($urandom_range(0, 70));
                it.chunk_bytes = $urandom_range(0, 1500);
                it.frame_bytes = $urandom_range(0, 95000);
            end
            2: begin
                it.frame_num = next_fid + $urandom_range(0, 3);
                it.chunk_count = 16'($urandom_range(1, 8));
                it.chunk_index = 16'($urandom_range(0, 9));
                it.chunk_bytes = $urandom_range(1, board.stride);
                it.datagram_len = 11'd1500;
                it.frame_bytes = $urandom_range(0, 12000);
            end
            default: it.command = CMD_SWEEP;
        endcase
        return it;
    endfunction

    task automatic send_frame(int cnt, bit shuffle, bit jpeg);
        int order [$];
        int fbytes, k;
        logic [31:0] fid;
        logic [15:0] head;
        fid = next_fid;
        next_fid += $urandom_range(1, 3);
        fbytes = (cnt - 1) * int'(board.stride) + int'($urandom_range(1, board.stride));
        if (fbytes > 64 * 1476) fbytes = 64 * 1476;
        head = jpeg ? JPEG_SOI : 16'($urandom);
        for (int i = 0; i < cnt; i++) order.push_back(i);
        if (shuffle) order.shuffle();
        foreach (order[i]) begin
            send_item(chunk_item(fid, order[i], cnt, fbytes,
                                 (order[i] == 1 && board.stride == 1) ? {head[7:0], 8'h00} :
                                 head));
            if ($urandom_range(0, 15) == 0) begin
                k = int'($urandom_range(0, i));
                send_item(chunk_item(fid, order[k], cnt, fbytes, head));
            end
        end
    endtask

    initial begin
        in_item_t it;
        int cnt;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_frame(1, 0, 1);
        send_frame(3, 0, 1);
        send_frame(2, 1, 0);
        it = chunk_item(1, 0, 1, 100, JPEG_SOI);
        send_item(it);
        it = chunk_item(next_fid, 0, 1, 2, JPEG_SOI);
        send_item(it);
        next_fid++;
        it = chunk_item(next_fid, 0, 1, 1476 * 64, JPEG_SOI);
        it.frame_bytes = 1476 * 64 + 1;
        send_item(it);
        it = chunk_item(next_fid, 1, 2, 100, 16'hFFFF);
        send_item(it);
        for (int i = 0; i < 5; i++) begin
            it = chunk_item(next_fid + i, 0, 2, 3000, JPEG_SOI);
            send_item(it);
        end
        it = '1;
        it.command = CMD_SWEEP;
        send_item(it);
        it = '0;
        it.command = CMD_SWEEP;
        it.now_ms = clock_ms + 1000;
        send_item(it);
        next_fid += 6;
        drain();

        write_reg(REG_CHUNK_PAYLOAD, 1);
        write_reg(REG_STALE_MS, 0);
        send_frame(2, 0, 1);
        send_frame(4, 1, 1);
        drain();
        write_reg(REG_CHUNK_PAYLOAD, 1476);
        write_reg(REG_STALE_MS, 16'hFFFF);

        for (int phase = 0; phase < 4; phase++) begin
            for (int n = 0; n < 400;) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        send_item(noise_item());
                        n++;
                    end
                    2: begin
                        it = '0;
                        it.command = CMD_SWEEP;
                        it.now_ms = clock_ms + $urandom_range(0, 400);
                        send_item(it);
                        n++;
                    end
                    default: begin
                        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) :
                              $urandom_range(1, 6);
                        send_frame(cnt, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
                        n += cnt;
                    end
                endcase
            end
            if (phase == 1) begin
                drain();
                write_reg(REG_CHUNK_PAYLOAD, 16'($urandom_range(1, 200)));
                write_reg(REG_STALE_MS, 16'($urandom_range(5, 60)));
            end else if (phase == 2) begin
                drain();
                write_reg(REG_CHUNK_PAYLOAD, 1376);
                write_reg(REG_STALE_MS, 200);
                calm = 1;
            end
        end

        s_valid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
